@@ src/traffic_cellular_automaton_step_unit_defines.svh @@
// Assertion macros used by the back end (tca_back).
`ifndef TRAFFIC_CELLULAR_AUTOMATON_STEP_UNIT_DEFINES_SVH
`define TRAFFIC_CELLULAR_AUTOMATON_STEP_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define TCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Signal free of X and Z at every rising clock edge outside reset.
`define TCA_ASSERT_KNOWN(lbl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    !$isunknown(sig)) else $error(msg);

`endif

@@ src/tca_pkg.sv @@
package tca_pkg;

  localparam int unsigned RoadCells = 64;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMaxSpeed    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSafeGap     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInjectPer   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlowProb    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRngSeed     = 3'd4;

  localparam logic [15:0] LfsrTaps = 16'hB400;

  typedef enum logic {
    KindLoad = 1'b0,
    KindTick = 1'b1
  } kind_e;

  // One classified command in the queue between front and back.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] cell_index;
    logic       car_present;
    logic [3:0] speed;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  max_speed;
    logic [3:0]  safe_gap;
    logic [15:0] inject_period;
    logic [15:0] slow_prob;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StInject,
    StScan,
    StMove,
    StEmitRd,
    StEmit
  } state_e;

  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) n = n ^ LfsrTaps;
    if (n == 16'd0) n = 16'd1;
    return n;
  endfunction

endpackage

@@ src/tca_ram.sv @@
module tca_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ src/tca_front.sv @@
module tca_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tca_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tca_pkg::cmd_t cmd_o
);
  import tca_pkg::*;

  // Two-entry queue decoupling the input side from the back end.
  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = buf_q[rp_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ src/tca_back.sv @@
`include "traffic_cellular_automaton_step_unit_defines.svh"
module tca_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tca_pkg::cmd_t cmd_i,
  input  tca_pkg::cfg_t cfg_i,
  input  logic          seed_we_i,
  input  logic [15:0]   seed_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [5:0]    idx_o,
  output logic          car_o,
  output logic [3:0]    spd_o,
  output logic          last_o
);
  import tca_pkg::*;

  localparam int unsigned AW = $clog2(RoadCells);
  localparam logic [AW:0] Cells = (AW+1)'(RoadCells);

  state_e st_q, st_d;
  logic   bank_q;                  // which RAM holds the current road
  logic [AW:0] ptr_q;
  logic [15:0] tick_q, lfsr_q;

  // Remainder of the tick count by the injection period, one bit per cycle.
  logic [15:0] rem_q, dvd_q, rem_nx;
  logic [3:0]  mcnt_q;
  logic [16:0] rem_sh;

  // Per-bank RAM ports.
  logic          we   [2];
  logic [AW-1:0] wa   [2];
  logic [4:0]    wd   [2];
  logic [AW-1:0] ra   [2];
  logic [4:0]    rd   [2];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    tca_ram #(.Width(5), .Depth(RoadCells)) u_ram (
      .clk_i, .we_i(we[b]), .waddr_i(wa[b]), .wdata_i(wd[b]),
      .raddr_i(ra[b]), .rdata_o(rd[b]));
  end

  // Occupancy bits per bank say which RAM entries hold a car, so the RAM
  // itself never needs clearing.
  logic [RoadCells-1:0] occ_q [2];
  logic [RoadCells-1:0] occ_cur;
  assign occ_cur = occ_q[bank_q];

  // Move phase: pointer walks up, tracking the nearest car ahead.
  logic          have_q;
  logic [AW-1:0] ahead_q;
  logic [AW-1:0] cur;
  logic          inj;
  logic [4:0]    rdc;
  logic          rd_ok_q;
  logic [AW-1:0] rd_idx_q;
  logic          out_v_q;
  logic [5:0]    oidx_q;
  logic          ocar_q, olast_q;
  logic [3:0]    ospd_q;
  logic          emit_adv;

  // Random draws must follow ascending car order, so the move pass goes
  // upward and finds the car ahead with a search over the occupancy bits.
  logic [AW-1:0] nxt_car;
  logic          nxt_ok;
  always_comb begin
    nxt_ok = 1'b0;
    nxt_car = '0;
    for (int j = RoadCells - 1; j >= 0; j--) begin
      if (occ_cur[j] && (AW+1)'(j) > ptr_q) begin
        nxt_ok = 1'b1;
        nxt_car = AW'(j);
      end
    end
  end

  assign cur = ptr_q[AW-1:0];
  assign rdc = occ_cur[rd_idx_q] ? rd[bank_q] : 5'd0;
  assign inj = (cfg_i.inject_period != 16'd0) && !occ_cur[0] && (rem_q == 16'd0);
  assign emit_adv = !out_v_q || ready_i;

  always_comb begin
    rem_sh = {rem_q, dvd_q[15]};
    rem_nx = (rem_sh >= {1'b0, cfg_i.inject_period}) ?
             16'(rem_sh - {1'b0, cfg_i.inject_period}) : rem_sh[15:0];
  end

  logic [4:0] v1, lim, v2;
  logic [15:0] r;
  logic [AW:0] dest;
  logic [AW:0] gap;
  always_comb begin
    v1 = {1'b0, rdc[3:0]} + 5'd1;
    if (v1 > {1'b0, cfg_i.max_speed}) v1 = {1'b0, cfg_i.max_speed};
    gap = {1'b0, ahead_q} - {1'b0, rd_idx_q};
    lim = 5'd0;
    if (gap > (AW+1)'(cfg_i.safe_gap)) begin
      lim = ((gap - (AW+1)'(cfg_i.safe_gap)) > (AW+1)'(15)) ? 5'd15 :
            5'((gap - (AW+1)'(cfg_i.safe_gap)));
    end
    v2 = (have_q && v1 > lim) ? lim : v1;
    r = lfsr_next(lfsr_q);
    if (cfg_i.slow_prob != 16'd0 && r < cfg_i.slow_prob && v2 != 5'd0) v2 = v2 - 5'd1;
    dest = {1'b0, rd_idx_q} + (AW+1)'(v2);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:   if (valid_i && cmd_i.kind == KindTick) st_d = StMod;
      StMod:    if (mcnt_q == 4'd15) st_d = StInject;
      StInject: st_d = StScan;
      StScan:   st_d = StMove;
      StMove:   if (ptr_q == Cells && !rd_ok_q) st_d = StEmitRd;
      StEmitRd: st_d = StEmit;
      StEmit:   if (out_v_q && ready_i && olast_q) st_d = StIdle;
      default:  st_d = StIdle;
    endcase
  end

  always_comb begin
    ready_o = (st_q == StIdle);
    for (int b = 0; b < 2; b++) begin
      we[b] = 1'b0; wa[b] = '0; wd[b] = '0; ra[b] = cur;
    end
    // A stalled result keeps its cell on the read port.
    if (st_q == StEmit && !emit_adv) ra[bank_q] = rd_idx_q;
    if (st_q == StIdle && valid_i && cmd_i.kind == KindLoad &&
        {1'b0, cmd_i.cell_index} < 7'(RoadCells)) begin
      we[bank_q] = 1'b1;
      wa[bank_q] = AW'(cmd_i.cell_index);
      wd[bank_q] = {cmd_i.car_present, cmd_i.car_present ? cmd_i.speed : 4'd0};
    end
    if (st_q == StInject && inj) begin
      we[bank_q] = 1'b1; wa[bank_q] = '0; wd[bank_q] = 5'h11;
    end
    if (st_q == StMove && rd_ok_q && occ_cur[rd_idx_q] && dest < Cells) begin
      we[~bank_q] = 1'b1; wa[~bank_q] = dest[AW-1:0]; wd[~bank_q] = {1'b1, v2[3:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      bank_q <= 1'b0;
      ptr_q <= '0;
      tick_q <= 16'd1;
      rem_q <= 16'd0;
      dvd_q <= 16'd0;
      mcnt_q <= 4'd0;
      lfsr_q <= 16'd1;
      occ_q[0] <= '0;
      occ_q[1] <= '0;
      have_q <= 1'b0;
      ahead_q <= '0;
      rd_ok_q <= 1'b0;
      rd_idx_q <= '0;
      out_v_q <= 1'b0;
      oidx_q <= 6'd0;
      ocar_q <= 1'b0;
      ospd_q <= 4'd0;
      olast_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (seed_we_i) lfsr_q <= (seed_i == 16'd0) ? 16'd1 : seed_i;
      else if (st_q == StMove && rd_ok_q && cfg_i.slow_prob != 16'd0) lfsr_q <= r;
      unique case (st_q)
        StIdle: begin
          if (valid_i && cmd_i.kind == KindLoad &&
              {1'b0, cmd_i.cell_index} < 7'(RoadCells))
            occ_q[bank_q][AW'(cmd_i.cell_index)] <= cmd_i.car_present;
          if (valid_i && cmd_i.kind == KindTick) begin
            rem_q <= 16'd0;
            dvd_q <= tick_q;
            mcnt_q <= 4'd0;
          end
        end
        StMod: begin
          rem_q <= rem_nx;
          dvd_q <= {dvd_q[14:0], 1'b0};
          mcnt_q <= mcnt_q + 4'd1;
        end
        StInject: begin
          if (inj) occ_q[bank_q][0] <= 1'b1;
          occ_q[~bank_q] <= '0;
        end
        StScan: begin
          ptr_q <= '0;
          rd_ok_q <= 1'b0;
        end
        StMove: begin
          // Issue a read for the car at ptr, process the one read last cycle.
          if (occ_cur[cur] && ptr_q < Cells) begin
            rd_ok_q <= 1'b1;
            rd_idx_q <= cur;
            have_q <= nxt_ok;
            ahead_q <= nxt_car;
          end else begin
            rd_ok_q <= 1'b0;
          end
          if (rd_ok_q && dest < Cells) occ_q[~bank_q][dest[AW-1:0]] <= 1'b1;
          if (st_d == StEmitRd) begin
            bank_q <= ~bank_q;
            ptr_q <= '0;
            tick_q <= tick_q + 16'd1;
          end else if (ptr_q < Cells) begin
            ptr_q <= ptr_q + (AW+1)'(1);
          end
        end
        StEmitRd: begin
          rd_idx_q <= cur;
          ptr_q <= ptr_q + (AW+1)'(1);
        end
        StEmit: begin
          if (emit_adv) begin
            if (ptr_q <= Cells) begin
              out_v_q <= 1'b1;
              oidx_q <= 6'(rd_idx_q);
              ocar_q <= occ_cur[rd_idx_q];
              ospd_q <= occ_cur[rd_idx_q] ? rd[bank_q][3:0] : 4'd0;
              olast_q <= ({1'b0, rd_idx_q} == Cells - (AW+1)'(1));
              rd_idx_q <= cur;
              ptr_q <= ptr_q + (AW+1)'(1);
            end else begin
              out_v_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign valid_o = out_v_q;
  assign idx_o   = oidx_q;
  assign car_o   = ocar_q;
  assign spd_o   = ospd_q;
  assign last_o  = olast_q;

  `TCA_ASSERT(a_no_take_busy, (st_q != StIdle) |-> !ready_o, "accept while busy")
  `TCA_ASSERT(a_out_emit, valid_o |-> (st_q == StEmit), "result outside emit")
  `TCA_ASSERT(a_hold, (valid_o && !ready_i) |=> (valid_o && $stable(idx_o)), "held result moved")
  `TCA_ASSERT_KNOWN(a_state_known, st_q, "state unknown")
endmodule

@@ src/traffic_cellular_automaton_step_unit.sv @@
// Channel   | Direction | Payload
// s_axis    | in        | tdata {speed, car_present, cell_index}, tuser kind
// m_axis    | out       | tdata {out_speed, out_car, out_index}, tlast last
// cfg       | in        | index 0..4, data 16 bits
// A load passes through the queue and the back end.
// A tick first works out the injection remainder bit by bit, then does
// one RAM read per cell in the move sweep, then one per cell while the road
// is streamed out.
// Reset empties the road through occupancy bits, with no clearing pass.
// Output stalls hold the sweep; the input queue keeps taking items until full.
module traffic_cellular_automaton_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cell_index[5:0], car_present[6], speed[10:7]
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_index[5:0], out_car[6], out_speed[10:7]
  output logic        m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [tca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tca_pkg::CfgDataW-1:0] cfg_data_i
);
  import tca_pkg::*;

  cfg_t cfg_q;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [5:0] oi;
  logic oc;
  logic [3:0] os;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_speed: 4'd5, safe_gap: 4'd1, inject_period: 16'd0, slow_prob: 16'd0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxSpeed:  cfg_q.max_speed <= cfg_data_i[3:0];
        CfgSafeGap:   cfg_q.safe_gap <= cfg_data_i[3:0];
        CfgInjectPer: cfg_q.inject_period <= cfg_data_i;
        CfgSlowProb:  cfg_q.slow_prob <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_cmd = '{kind: kind_e'(s_axis_tuser), cell_index: s_axis_tdata[5:0],
                    car_present: s_axis_tdata[6], speed: s_axis_tdata[10:7]};

  tca_front u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready), .cmd_i(in_cmd),
    .valid_o(q_valid), .ready_i(q_ready), .cmd_o(q_cmd));

  tca_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .ready_o(q_ready), .cmd_i(q_cmd), .cfg_i(cfg_q),
    .seed_we_i(cfg_we_i && cfg_idx_i == CfgRngSeed), .seed_i(cfg_data_i),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .idx_o(oi), .car_o(oc),
    .spd_o(os), .last_o(m_axis_tlast));

  assign m_axis_tdata = {5'd0, os, oc, oi};
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tca_pkg::*;

  localparam int unsigned NumCells  = 64;
  localparam int unsigned TickDrain = 2 * NumCells + 80;
  localparam int unsigned MaxCycles = 3_000_000;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] cidx;
    logic       car;
    logic [3:0] spd;
  } road_cmd_t;

  typedef struct packed {
    logic [5:0] cidx;
    logic       car;
    logic [3:0] spd;
    logic       last;
  } cell_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  traffic_cellular_automaton_step_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  // Road state and settings as the block should hold them.
  logic        road_car [NumCells];
  logic [3:0]  road_spd [NumCells];
  logic [15:0] tick_cnt;
  logic [15:0] rng_state;
  logic [3:0]  max_speed;
  logic [3:0]  safe_gap;
  logic [15:0] inject_period;
  logic [15:0] slow_prob;

  road_cmd_t pending_cmds[$];
  cell_out_t expected_cells[$];

  int unsigned fail_count = 0;
  int unsigned cells_checked = 0;
  int unsigned ticks_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned cycle_count = 0;
  logic in_taken = 1'b0;
  bit long_hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("traffic_cellular_automaton_step_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] rng_advance(input logic [15:0] s);
    logic [15:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ 16'hB400;
    if (n == 16'd0) n = 16'd1;
    return n;
  endfunction

  task automatic apply_command(input road_cmd_t c);
    logic       nxt_car [NumCells];
    logic [3:0] nxt_spd [NumCells];
    int         gap_len [NumCells];
    int         ahead;
    int         v;
    int         lim;
    int         dest;
    cell_out_t  o;
    if (c.kind == KindLoad) begin
      road_car[c.cidx] = c.car;
      road_spd[c.cidx] = c.car ? c.spd : 4'd0;
      return;
    end
    if (inject_period != 0 && !road_car[0] && (tick_cnt % inject_period) == 0) begin
      road_car[0] = 1'b1;
      road_spd[0] = 4'd1;
    end
    ahead = -1;
    for (int i = NumCells - 1; i >= 0; i--) begin
      gap_len[i] = (ahead < 0) ? -1 : ahead - i;
      if (road_car[i]) ahead = i;
      nxt_car[i] = 1'b0;
      nxt_spd[i] = 4'd0;
    end
    for (int i = 0; i < NumCells; i++) begin
      if (road_car[i]) begin
        v = road_spd[i] + 1;
        if (v > max_speed) v = max_speed;
        if (gap_len[i] >= 0) begin
          lim = (gap_len[i] > safe_gap) ? gap_len[i] - safe_gap : 0;
          if (v > lim) v = lim;
        end
        if (slow_prob != 0) begin
          rng_state = rng_advance(rng_state);
          if (rng_state < slow_prob && v > 0) v = v - 1;
        end
        dest = i + v;
        // Ascending order means the car from the higher cell writes last.
        if (dest < NumCells) begin
          nxt_car[dest] = 1'b1;
          nxt_spd[dest] = v[3:0];
        end
      end
    end
    tick_cnt = tick_cnt + 16'd1;
    for (int i = 0; i < NumCells; i++) begin
      road_car[i] = nxt_car[i];
      road_spd[i] = nxt_spd[i];
      o.cidx = i[5:0];
      o.car = nxt_car[i];
      o.spd = nxt_spd[i];
      o.last = (i == NumCells - 1);
      expected_cells.push_back(o);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk) begin
    road_cmd_t c;
    if (rst_n && (!s_axis_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.kind;
        s_axis_tdata <= {5'd0, c.spd, c.car, c.cidx};
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
        end else begin
          burst_left = burst_left - 1;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Input transfer: the expected road is updated as each item is accepted.
  always @(posedge clk) begin
    road_cmd_t c;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_n && s_axis_tvalid && s_axis_tready) begin
      c.kind = kind_e'(s_axis_tuser);
      c.cidx = s_axis_tdata[5:0];
      c.car = s_axis_tdata[6];
      c.spd = s_axis_tdata[10:7];
      if (c.kind == KindTick) ticks_sent++;
      else loads_sent++;
      apply_command(c);
    end
  end

  // Receiver: random stall patterns, plus one long hold-off.
  int unsigned rdy_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      hold_left = 1500;
      long_hold_req = 1'b0;
    end
    if (mode_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(8, 80);
    end else begin
      mode_left = mode_left - 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rdy_mode)
        0, 1: m_axis_tready <= 1'b1;
        2: m_axis_tready <= $urandom_range(0, 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cell_out_t e;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (expected_cells.size() == 0) begin
        $error("Output transfer with no expected cell: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        e = expected_cells.pop_front();
        cells_checked++;
        if (m_axis_tdata[5:0] !== e.cidx) begin
          $error("out_index: expected %0d, got %0d", e.cidx, m_axis_tdata[5:0]);
          fail_count++;
        end
        if (m_axis_tdata[6] !== e.car) begin
          $error("out_car: expected %0d, got %0d", e.car, m_axis_tdata[6]);
          fail_count++;
        end
        if (m_axis_tdata[10:7] !== e.spd) begin
          $error("out_speed: expected %0d, got %0d", e.spd, m_axis_tdata[10:7]);
          fail_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  task automatic push_cmd(input kind_e k, input int cidx, input int car, input int spd);
    road_cmd_t c;
    c.kind = k;
    c.cidx = cidx[5:0];
    c.car = car[0];
    c.spd = spd[3:0];
    pending_cmds.push_back(c);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgMaxSpeed:  max_speed = val[3:0];
      CfgSafeGap:   safe_gap = val[3:0];
      CfgInjectPer: inject_period = val;
      CfgSlowProb:  slow_prob = val;
      CfgRngSeed:   rng_state = (val == 16'd0) ? 16'd1 : val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    wait (pending_cmds.size() == 0 && !s_axis_tvalid && expected_cells.size() == 0);
    repeat (TickDrain) @(posedge clk);
  endtask

  task automatic set_all(input int ms, input int sg, input int per, input int sp, input int seed);
    cfg_write(CfgMaxSpeed, ms[15:0]);
    cfg_write(CfgSafeGap, sg[15:0]);
    cfg_write(CfgInjectPer, per[15:0]);
    cfg_write(CfgSlowProb, sp[15:0]);
    cfg_write(CfgRngSeed, seed[15:0]);
  endtask

  // Mostly well-formed traffic: a handful of loads followed by several ticks.
  task automatic random_traffic(input int n_items);
    int left;
    int k;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        push_cmd(kind_e'($urandom_range(0, 1)), $urandom_range(0, 63),
                 $urandom_range(0, 1), $urandom_range(0, 15));
        left--;
      end else begin
        k = $urandom_range(0, 8);
        for (int i = 0; i < k && left > 0; i++) begin
          push_cmd(KindLoad, $urandom_range(0, 63), ($urandom_range(0, 3) != 0),
                   $urandom_range(0, 15));
          left--;
        end
        k = $urandom_range(1, 5);
        for (int i = 0; i < k && left > 0; i++) begin
          push_cmd(KindTick, 0, 0, 0);
          left--;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NumCells; i++) begin
      road_car[i] = 1'b0;
      road_spd[i] = 4'd0;
    end
    tick_cnt = 16'd1;
    rng_state = 16'd1;
    max_speed = 4'd5;
    safe_gap = 4'd1;
    inject_period = 16'd0;
    slow_prob = 16'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: extreme cells and speeds, empty loads.
    push_cmd(KindLoad, 0, 1, 15);
    push_cmd(KindLoad, 63, 1, 0);
    push_cmd(KindLoad, 62, 0, 15);
    push_cmd(KindLoad, 31, 1, 7);
    push_cmd(KindLoad, 32, 1, 15);
    push_cmd(KindTick, 63, 1, 15);
    push_cmd(KindTick, 0, 0, 0);
    push_cmd(KindLoad, 10, 1, 3);
    push_cmd(KindLoad, 11, 1, 0);
    push_cmd(KindLoad, 12, 1, 0);
    push_cmd(KindLoad, 10, 0, 9);
    push_cmd(KindTick, 0, 0, 0);
    push_cmd(KindTick, 0, 0, 0);
    wait_idle();

    // Injection every tick, no safety gap, constant slowdown and a zero seed.
    set_all(15, 0, 1, 65535, 0);
    for (int i = 0; i < 6; i++) push_cmd(KindTick, 0, 0, 0);
    push_cmd(KindLoad, 60, 1, 15);
    push_cmd(KindLoad, 61, 1, 15);
    push_cmd(KindTick, 0, 0, 0);
    random_traffic(70);
    wait_idle();

    // Slowest cars, widest gap; the long hold-off fills the block up.
    set_all(1, 15, 65535, 1, 65535);
    long_hold_req = 1'b1;
    random_traffic(80);
    wait_idle();

    // Standing cars.
    set_all(0, 1, 2, 32768, 16'hACE1);
    push_cmd(KindLoad, 5, 1, 15);
    push_cmd(KindTick, 0, 0, 0);
    push_cmd(KindTick, 0, 0, 0);
    random_traffic(30);
    wait_idle();

    set_all(7, 2, 3, 8000, $urandom_range(1, 65535));
    random_traffic(100);
    wait_idle();

    set_all($urandom_range(1, 15), $urandom_range(0, 15), $urandom_range(0, 6),
            $urandom_range(0, 65535), $urandom_range(0, 65535));
    random_traffic(100);
    wait_idle();

    $display("Covered %0d ticks and %0d loads over six settings; %0d cells compared.",
             ticks_sent, loads_sent, cells_checked);
    if (fail_count == 0) begin
      $display("traffic_cellular_automaton_step_unit: match");
    end else begin
      $display("traffic_cellular_automaton_step_unit: mismatch");
    end
    $finish;
  end

endmodule
